>>> hdl/mscf_pkg.sv
// Shared types, codes and constants of the memory search candidate filter.
package mscf_pkg;

   localparam int MEM_BYTES_DEFAULT      = 8192;
   localparam int MAX_CANDIDATES_DEFAULT = 16384;

   localparam int ADDR_W   = 13;
   localparam int VALUE_W  = 32;
   localparam int TOTAL_W  = 15;
   localparam int INDEX_W  = 14;
   localparam int ASM_W    = 24;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 2;

   localparam logic [1:0] KIND_SNAPSHOT = 2'd0;
   localparam logic [1:0] KIND_COMPARE  = 2'd1;
   localparam logic [1:0] KIND_FINISH   = 2'd2;
   localparam logic [1:0] KIND_READ     = 2'd3;

   localparam logic [1:0] MODE_NIBBLE = 2'd0;
   localparam logic [1:0] MODE_BYTE   = 2'd1;
   localparam logic [1:0] MODE_HALF   = 2'd2;
   localparam logic [1:0] MODE_WORD   = 2'd3;

   localparam logic [2:0] REL_EQ = 3'd0;
   localparam logic [2:0] REL_LT = 3'd1;
   localparam logic [2:0] REL_LE = 3'd2;
   localparam logic [2:0] REL_GT = 3'd3;
   localparam logic [2:0] REL_GE = 3'd4;
   localparam logic [2:0] REL_NE = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE_MODE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_PREVIOUS_VALUE = 1'd1;

   localparam logic [1:0] UNIT_SIZE_MODE_RESET     = MODE_HALF;
   localparam logic       USE_PREVIOUS_VALUE_RESET = 1'b1;

   typedef struct packed {
      logic [1:0]         kind;
      logic [ADDR_W-1:0]  byte_addr;
      logic [7:0]         mem_byte;
      logic [2:0]         relation;
      logic [VALUE_W-1:0] test_value;
      logic [INDEX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] candidate_total;
      logic               found;
      logic [ADDR_W-1:0]  entry_address;
      logic               entry_upper_half;
      logic [VALUE_W-1:0] entry_value;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic               upper;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic snap_first;
      logic snap_upper;
      logic cmp_start;
      logic tab_read_rp;
      logic cmp_eval;
      logic finish;
      logic tab_read_idx;
      logic entry_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_kind;
      logic       in_addr_ok;
      logic       nibble;
      logic       unit_done;
      logic       entry_ok;
      logic       entry_above;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SNAP,
      ST_SNAP_HI,
      ST_CMP_ASM,
      ST_CMP_RD,
      ST_CMP_EVAL,
      ST_FINISH,
      ST_RD_ISSUE,
      ST_RD_LOAD
   } ctrl_state_type;

endpackage

>>> hdl/mscf_ctrl.sv
// Sequencing state machine and result valid flag of the candidate filter.
module mscf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mscf_pkg::status_type status,
   output mscf_pkg::cmd_type    cmd
);

   mscf_pkg::ctrl_state_type state_ff, state_in;
   logic second_ff, second_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign req_stall = (state_ff != mscf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mscf_pkg::ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      second_in = second_ff;
      cmd       = '0;
      case (state_ff)
         mscf_pkg::ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (status.in_kind)
                  mscf_pkg::KIND_SNAPSHOT: begin
                     if (status.in_addr_ok) state_in = mscf_pkg::ST_SNAP;
                  end
                  mscf_pkg::KIND_COMPARE: begin
                     if (status.in_addr_ok) state_in = mscf_pkg::ST_CMP_ASM;
                  end
                  mscf_pkg::KIND_FINISH: state_in = mscf_pkg::ST_FINISH;
                  default:               state_in = mscf_pkg::ST_RD_ISSUE;
               endcase
            end
         end
         mscf_pkg::ST_SNAP: begin
            cmd.snap_first = 1'b1;
            state_in = status.nibble ? mscf_pkg::ST_SNAP_HI : mscf_pkg::ST_IDLE;
         end
         mscf_pkg::ST_SNAP_HI: begin
            cmd.snap_upper = 1'b1;
            state_in = mscf_pkg::ST_IDLE;
         end
         mscf_pkg::ST_CMP_ASM: begin
            cmd.cmp_start = 1'b1;
            second_in = 1'b0;
            state_in = status.unit_done ? mscf_pkg::ST_CMP_RD : mscf_pkg::ST_IDLE;
         end
         mscf_pkg::ST_CMP_RD: begin
            if (status.entry_ok) begin
               cmd.tab_read_rp = 1'b1;
               state_in = mscf_pkg::ST_CMP_EVAL;
            end else begin
               state_in = mscf_pkg::ST_IDLE;
            end
         end
         mscf_pkg::ST_CMP_EVAL: begin
            if (status.entry_above) begin
               state_in = mscf_pkg::ST_IDLE;
            end else begin
               cmd.cmp_eval = 1'b1;
               if (!second_ff) begin
                  second_in = 1'b1;
                  state_in  = mscf_pkg::ST_CMP_RD;
               end else begin
                  state_in  = mscf_pkg::ST_IDLE;
               end
            end
         end
         mscf_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in = mscf_pkg::ST_IDLE;
            end
         end
         mscf_pkg::ST_RD_ISSUE: begin
            cmd.tab_read_idx = 1'b1;
            state_in = mscf_pkg::ST_RD_LOAD;
         end
         mscf_pkg::ST_RD_LOAD: begin
            if (out_free) begin
               cmd.entry_load = 1'b1;
               state_in = mscf_pkg::ST_IDLE;
            end
         end
         default: state_in = mscf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.finish || cmd.entry_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // a result is never loaded over one still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.entry_load) |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish || cmd.entry_load) |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.finish || cmd.entry_load))
      else $error("result valid without a load");

endmodule

>>> hdl/mscf_datapath.sv
// Candidate table, pass pointers, unit assembly, compare and result register.
module mscf_datapath #(
   parameter int MEM_BYTES      = mscf_pkg::MEM_BYTES_DEFAULT,
   parameter int MAX_CANDIDATES = mscf_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mscf_pkg::req_type                   req_data,
   output mscf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [mscf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mscf_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  mscf_pkg::cmd_type                   cmd,
   output mscf_pkg::status_type                status
);

   localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int IDX_W = $clog2(MAX_CANDIDATES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CANDIDATES);

   mscf_pkg::entry_type mem [MAX_CANDIDATES];

   mscf_pkg::req_type   req_ff, req_in;
   logic [1:0]          mode_ff, mode_in;
   logic                use_prev_ff, use_prev_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rp_ff, rp_in;
   logic [CNT_W-1:0]    wp_ff, wp_in;
   logic [mscf_pkg::ASM_W-1:0]   asm_ff, asm_in;
   logic                found_ff, found_in;
   logic [mscf_pkg::ADDR_W-1:0]  ua_ff, ua_in;
   logic [mscf_pkg::VALUE_W-1:0] uv_ff, uv_in;
   logic                in_range_ff, in_range_in;
   mscf_pkg::entry_type rd_data_ff;
   mscf_pkg::rsp_type   rsp_ff, rsp_in;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_idx;
   mscf_pkg::entry_type wr_entry;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_idx;

   logic [mscf_pkg::ADDR_W-1:0]  a;
   logic [7:0]                   b;
   logic                         pass_start;
   logic [CNT_W-1:0]             wp_base;
   logic [mscf_pkg::ASM_W-1:0]   asm_base;
   logic [mscf_pkg::ASM_W-1:0]   asm_next;
   logic                         unit_done;
   logic [mscf_pkg::ADDR_W-1:0]  unit_addr;
   logic [mscf_pkg::VALUE_W-1:0] unit_value;
   logic [mscf_pkg::VALUE_W-1:0] live;
   logic [mscf_pkg::VALUE_W-1:0] ref_value;
   logic                         match;
   logic [31:0]                  idx32;
   logic [31:0]                  count32;
   logic [31:0]                  wp32;

   function automatic logic rel_holds(input logic [2:0] rel,
                                      input logic [31:0] x,
                                      input logic [31:0] y);
      logic r;
      case (rel)
         mscf_pkg::REL_EQ: r = (x == y);
         mscf_pkg::REL_LT: r = (x < y);
         mscf_pkg::REL_LE: r = (x <= y);
         mscf_pkg::REL_GT: r = (x > y);
         mscf_pkg::REL_GE: r = (x >= y);
         mscf_pkg::REL_NE: r = (x != y);
         default:          r = 1'b0;
      endcase
      return r;
   endfunction

   assign a          = req_ff.byte_addr;
   assign b          = req_ff.mem_byte;
   assign pass_start = (a == '0);
   assign wp_base    = pass_start ? '0 : wp_ff;
   assign asm_base   = pass_start ? '0 : asm_ff;
   assign idx32      = 32'(req_ff.entry_index);
   assign count32    = 32'(count_ff);
   assign wp32       = 32'(wp_ff);

   // unit assembly
   always_comb begin
      unit_done  = 1'b0;
      unit_addr  = a;
      unit_value = {24'h0, b};
      asm_next   = asm_base;
      case (mode_ff)
         mscf_pkg::MODE_NIBBLE, mscf_pkg::MODE_BYTE: unit_done = 1'b1;
         mscf_pkg::MODE_HALF: begin
            if (!a[0]) begin
               asm_next = {16'h0, b};
            end else begin
               unit_done  = 1'b1;
               unit_addr  = {a[mscf_pkg::ADDR_W-1:1], 1'b0};
               unit_value = {16'h0, b, asm_base[7:0]};
            end
         end
         mscf_pkg::MODE_WORD: begin
            case (a[1:0])
               2'd0: asm_next = {16'h0, b};
               2'd1: asm_next = asm_base | {8'h0, b, 8'h0};
               2'd2: asm_next = asm_base | {b, 16'h0};
               default: begin
                  unit_done  = 1'b1;
                  unit_addr  = {a[mscf_pkg::ADDR_W-1:2], 2'b00};
                  unit_value = {b, asm_base};
               end
            endcase
         end
         default: ;
      endcase
   end

   // live unit against reference for the entry just read
   always_comb begin
      if (mode_ff == mscf_pkg::MODE_NIBBLE) begin
         live = rd_data_ff.upper ? {28'h0, b[7:4]} : {28'h0, b[3:0]};
      end else begin
         live = uv_ff;
      end
      ref_value = use_prev_ff ? rd_data_ff.value : req_ff.test_value;
      match     = rel_holds(req_ff.relation, live, ref_value);
   end

   always_comb begin
      status.in_kind     = req_data.kind;
      status.in_addr_ok  = (32'(req_data.byte_addr) < 32'(MEM_BYTES));
      status.nibble      = (mode_ff == mscf_pkg::MODE_NIBBLE);
      status.unit_done   = unit_done;
      status.entry_ok    = (rp_ff < count_ff) && (rp_ff < MAX_CNT);
      status.entry_above = (rd_data_ff.address > ua_ff);
   end

   always_comb begin
      req_in      = req_ff;
      count_in    = count_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      asm_in      = asm_ff;
      found_in    = found_ff;
      ua_in       = ua_ff;
      uv_in       = uv_ff;
      in_range_in = in_range_ff;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_idx      = wp_ff[IDX_W-1:0];
      wr_entry    = '0;
      rd_en       = 1'b0;
      rd_idx      = rp_ff[IDX_W-1:0];

      if (cmd.capture) begin
         req_in = req_data;
      end

      if (cmd.snap_first) begin
         asm_in = asm_next;
         wp_in  = wp_base;
         if ((status.nibble || unit_done) && (wp_base < MAX_CNT)) begin
            wr_en            = 1'b1;
            wr_idx           = wp_base[IDX_W-1:0];
            wr_entry.address = unit_addr;
            wr_entry.upper   = 1'b0;
            wr_entry.value   = status.nibble ? {28'h0, b[3:0]} : unit_value;
            wp_in            = wp_base + CNT_W'(1);
         end
         count_in = wp_in;
      end

      if (cmd.snap_upper) begin
         if (wp_ff < MAX_CNT) begin
            wr_en            = 1'b1;
            wr_entry.address = a;
            wr_entry.upper   = 1'b1;
            wr_entry.value   = {28'h0, b[7:4]};
            wp_in            = wp_ff + CNT_W'(1);
         end
         count_in = wp_in;
      end

      if (cmd.cmp_start) begin
         if (pass_start) rp_in = '0;
         wp_in  = wp_base;
         asm_in = asm_next;
         ua_in  = unit_addr;
         uv_in  = unit_value;
      end

      if (cmd.tab_read_rp) begin
         rd_en = 1'b1;
      end

      if (cmd.cmp_eval && !status.entry_above) begin
         rp_in = rp_ff + CNT_W'(1);
         if ((rd_data_ff.address == ua_ff) && match && (wp_ff < MAX_CNT)) begin
            wr_en            = 1'b1;
            wr_entry.address = rd_data_ff.address;
            wr_entry.upper   = rd_data_ff.upper;
            wr_entry.value   = live;
            wp_in            = wp_ff + CNT_W'(1);
         end
      end

      if (cmd.finish) begin
         found_in = (wp_ff != '0);
         rsp_in   = '0;
         if (wp_ff != '0) begin
            count_in               = wp_ff;
            rsp_in.candidate_total = wp32[mscf_pkg::TOTAL_W-1:0];
         end else begin
            rsp_in.candidate_total = count32[mscf_pkg::TOTAL_W-1:0];
         end
         rsp_in.found = (wp_ff != '0);
      end

      if (cmd.tab_read_idx) begin
         rd_en       = 1'b1;
         rd_idx      = IDX_W'(idx32);
         in_range_in = (idx32 < count32) && (idx32 < 32'(MAX_CANDIDATES));
      end

      if (cmd.entry_load) begin
         rsp_in.candidate_total = count32[mscf_pkg::TOTAL_W-1:0];
         rsp_in.found           = found_ff;
         if (in_range_ff) begin
            rsp_in.entry_address    = rd_data_ff.address;
            rsp_in.entry_upper_half = rd_data_ff.upper;
            rsp_in.entry_value      = rd_data_ff.value;
         end else begin
            rsp_in.entry_address    = '0;
            rsp_in.entry_upper_half = 1'b0;
            rsp_in.entry_value      = '0;
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      use_prev_in = use_prev_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mscf_pkg::CSR_UNIT_SIZE_MODE:     mode_in     = csr_write_data[1:0];
            mscf_pkg::CSR_USE_PREVIOUS_VALUE: use_prev_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= mscf_pkg::UNIT_SIZE_MODE_RESET;
         use_prev_ff <= mscf_pkg::USE_PREVIOUS_VALUE_RESET;
         count_ff    <= '0;
         rp_ff       <= '0;
         wp_ff       <= '0;
         asm_ff      <= '0;
         found_ff    <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         use_prev_ff <= use_prev_in;
         count_ff    <= count_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         asm_ff      <= asm_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      ua_ff       <= ua_in;
      uv_ff       <= uv_in;
      in_range_ff <= in_range_in;
      rsp_ff      <= rsp_in;
   end

   // candidate table: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_entry;
      if (rd_en) rd_data_ff <= mem[rd_idx];
   end

   assign rsp_data = rsp_ff;

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= MAX_CNT)
      else $error("write pointer past table end");

   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= MAX_CNT)
      else $error("read pointer past table end");

   a_eval_order: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_eval |-> !(rd_data_ff.address > ua_ff))
      else $error("entry above unit evaluated");

endmodule

>>> hdl/memory_search_candidate_filter.sv
// Top level of the memory search candidate filter.
//
//   port group  dir  handshake            payload
//   req_        in   req_valid/req_stall  mscf_pkg::req_type
//   rsp_        out  rsp_valid/rsp_stall  mscf_pkg::rsp_type
//   csr_        in   csr_write_enable     csr_index, csr_write_data
//
// Snapshot byte, a table write (two in nibble mode, through the single write
// port); compare byte, unit assembly, then table read and evaluate per
// examined entry, at most two; finish, result load; entry read, table read and
// result load. Finish and entry read wait in place while the result register
// is held. Synchronous reset clears pointers, count, found flag and assembly,
// and loads the register reset values; the candidate table is not cleared.
module memory_search_candidate_filter #(
   parameter int MEM_BYTES      = mscf_pkg::MEM_BYTES_DEFAULT,
   parameter int MAX_CANDIDATES = mscf_pkg::MAX_CANDIDATES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mscf_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mscf_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [mscf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mscf_pkg::CSR_DATA_W-1:0] csr_write_data
);

   mscf_pkg::cmd_type    cmd;
   mscf_pkg::status_type status;

   mscf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mscf_datapath #(
      .MEM_BYTES      (MEM_BYTES),
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

>>> tb/sv/candidate_filter_checker.sv
// Checker for the candidate filter: tracks requests and registers, predicts results, compares.
module candidate_filter_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  mscf_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  mscf_pkg::rsp_type               rsp_data,
   input  logic                            csr_write_enable,
   input  logic [mscf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mscf_pkg::CSR_DATA_W-1:0] csr_write_data,
   output int                              mismatch_count,
   output int                              outstanding
);

   localparam int MEM_BYTES    = mscf_pkg::MEM_BYTES_DEFAULT;
   localparam int TABLE_DEPTH  = mscf_pkg::MAX_CANDIDATES_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   logic [mscf_pkg::ADDR_W-1:0]  cand_addr  [TABLE_DEPTH];
   logic                         cand_upper [TABLE_DEPTH];
   logic [mscf_pkg::VALUE_W-1:0] cand_value [TABLE_DEPTH];
   int unsigned                  cand_count;
   int unsigned                  scan_ptr;
   int unsigned                  keep_ptr;
   logic [mscf_pkg::ASM_W-1:0]   partial_unit;
   logic                         found_flag;
   logic [1:0]                   unit_mode;
   logic                         compare_previous;
   mscf_pkg::rsp_type            pending_reports [$];
   int                           mismatches = 0;

   function automatic void keep_candidate(input logic [mscf_pkg::ADDR_W-1:0] addr,
                                          input logic upper,
                                          input logic [mscf_pkg::VALUE_W-1:0] value);
      if (keep_ptr < TABLE_DEPTH) begin
         cand_addr[keep_ptr]  = addr;
         cand_upper[keep_ptr] = upper;
         cand_value[keep_ptr] = value;
         keep_ptr++;
      end
   endfunction

   function automatic bit relation_holds(input logic [2:0] rel,
                                         input logic [mscf_pkg::VALUE_W-1:0] live,
                                         input logic [mscf_pkg::VALUE_W-1:0] target);
      case (rel)
         mscf_pkg::REL_EQ: return live == target;
         mscf_pkg::REL_LT: return live < target;
         mscf_pkg::REL_LE: return live <= target;
         mscf_pkg::REL_GT: return live > target;
         mscf_pkg::REL_GE: return live >= target;
         mscf_pkg::REL_NE: return live != target;
         default: return 1'b0;
      endcase
   endfunction

   // Returns 1 when this byte closes a unit; halfword/word units reuse the assembly register.
   function automatic bit unit_complete(input logic [mscf_pkg::ADDR_W-1:0] addr,
                                        input logic [7:0] data,
                                        output logic [mscf_pkg::ADDR_W-1:0] unit_addr,
                                        output logic [mscf_pkg::VALUE_W-1:0] unit_value);
      unit_addr  = addr;
      unit_value = {24'd0, data};
      if (unit_mode == mscf_pkg::MODE_NIBBLE || unit_mode == mscf_pkg::MODE_BYTE)
         return 1'b1;
      if (unit_mode == mscf_pkg::MODE_HALF) begin
         if (!addr[0]) begin
            partial_unit = {16'd0, data};
            return 1'b0;
         end
         unit_addr  = {addr[mscf_pkg::ADDR_W-1:1], 1'b0};
         unit_value = {16'd0, data, partial_unit[7:0]};
         return 1'b1;
      end
      if (addr[1:0] == 2'd0) begin
         partial_unit = {16'd0, data};
         return 1'b0;
      end
      if (addr[1:0] != 2'd3) begin
         partial_unit = partial_unit | ({16'd0, data} << (8 * addr[1:0]));
         return 1'b0;
      end
      unit_addr  = {addr[mscf_pkg::ADDR_W-1:2], 2'b00};
      unit_value = {data, partial_unit};
      return 1'b1;
   endfunction

   function automatic void advance_search(input mscf_pkg::req_type r);
      logic [mscf_pkg::ADDR_W-1:0]  unit_addr;
      logic [mscf_pkg::VALUE_W-1:0] unit_value;
      logic [mscf_pkg::VALUE_W-1:0] live;
      logic [mscf_pkg::VALUE_W-1:0] target;
      int unsigned                  e;
      mscf_pkg::rsp_type            report;
      report = '0;
      if (r.kind == mscf_pkg::KIND_SNAPSHOT || r.kind == mscf_pkg::KIND_COMPARE) begin
         if (r.byte_addr >= MEM_BYTES)
            return;
         if (r.byte_addr == '0) begin
            keep_ptr     = 0;
            partial_unit = '0;
            if (r.kind == mscf_pkg::KIND_COMPARE)
               scan_ptr = 0;
         end
      end
      case (r.kind)
         mscf_pkg::KIND_SNAPSHOT: begin
            if (unit_mode == mscf_pkg::MODE_NIBBLE) begin
               keep_candidate(r.byte_addr, 1'b0, {28'd0, r.mem_byte[3:0]});
               keep_candidate(r.byte_addr, 1'b1, {28'd0, r.mem_byte[7:4]});
            end else if (unit_complete(r.byte_addr, r.mem_byte, unit_addr, unit_value)) begin
               keep_candidate(unit_addr, 1'b0, unit_value);
            end
            cand_count = keep_ptr;
         end
         mscf_pkg::KIND_COMPARE: begin
            if (!unit_complete(r.byte_addr, r.mem_byte, unit_addr, unit_value))
               return;
            // at most two entries per unit; lower addresses drop, higher ones wait
            for (int n = 0; n < 2; n++) begin
               e = scan_ptr;
               if (e >= cand_count || e >= TABLE_DEPTH || cand_addr[e] > unit_addr)
                  break;
               scan_ptr++;
               if (cand_addr[e] < unit_addr)
                  continue;
               if (unit_mode == mscf_pkg::MODE_NIBBLE)
                  live = {28'd0, (cand_upper[e] ? r.mem_byte[7:4] : r.mem_byte[3:0])};
               else
                  live = unit_value;
               target = compare_previous ? cand_value[e] : r.test_value;
               if (relation_holds(r.relation, live, target) && keep_ptr < TABLE_DEPTH) begin
                  cand_addr[keep_ptr]  = cand_addr[e];
                  cand_upper[keep_ptr] = cand_upper[e];
                  cand_value[keep_ptr] = live;
                  keep_ptr++;
               end
            end
         end
         mscf_pkg::KIND_FINISH: begin
            found_flag = keep_ptr > 0;
            if (found_flag)
               cand_count = keep_ptr;
            report.candidate_total = cand_count[mscf_pkg::TOTAL_W-1:0];
            report.found           = found_flag;
            pending_reports = {pending_reports, report};
         end
         default: begin
            report.candidate_total = cand_count[mscf_pkg::TOTAL_W-1:0];
            report.found           = found_flag;
            if (r.entry_index < cand_count && r.entry_index < TABLE_DEPTH) begin
               report.entry_address    = cand_addr[r.entry_index];
               report.entry_upper_half = cand_upper[r.entry_index];
               report.entry_value      = cand_value[r.entry_index];
            end
            pending_reports = {pending_reports, report};
         end
      endcase
   endfunction

   always @(posedge clock) begin
      mscf_pkg::rsp_type expected;
      if (reset) begin
         cand_count       = 0;
         scan_ptr         = 0;
         keep_ptr         = 0;
         partial_unit     = '0;
         found_flag       = 1'b0;
         unit_mode        = mscf_pkg::UNIT_SIZE_MODE_RESET;
         compare_previous = mscf_pkg::USE_PREVIOUS_VALUE_RESET;
         pending_reports.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mscf_pkg::CSR_UNIT_SIZE_MODE:     unit_mode = csr_write_data[1:0];
               mscf_pkg::CSR_USE_PREVIOUS_VALUE: compare_previous = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            advance_search(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected result: total=%0d found=%0b addr=%0d upper=%0b value=%h",
                           rsp_data.candidate_total, rsp_data.found, rsp_data.entry_address,
                           rsp_data.entry_upper_half, rsp_data.entry_value);
            end else begin
               expected = pending_reports.pop_front();
               if (rsp_data.candidate_total !== expected.candidate_total ||
                   rsp_data.found !== expected.found ||
                   rsp_data.entry_address !== expected.entry_address ||
                   rsp_data.entry_upper_half !== expected.entry_upper_half ||
                   rsp_data.entry_value !== expected.entry_value) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"result mismatch: expected total=%0d found=%0b addr=%0d ",
                               "upper=%0b value=%h, got total=%0d found=%0b addr=%0d ",
                               "upper=%0b value=%h"},
                              expected.candidate_total, expected.found,
                              expected.entry_address, expected.entry_upper_half,
                              expected.entry_value, rsp_data.candidate_total, rsp_data.found,
                              rsp_data.entry_address, rsp_data.entry_upper_half,
                              rsp_data.entry_value);
               end
            end
         end
      end
      mismatch_count <= mismatches;
      outstanding    <= pending_reports.size();
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the candidate filter testbench: clock, reset, stimulus, stalls, watchdog and verdict.
module testbench;

   localparam int MEM_SPAN       = mscf_pkg::MEM_BYTES_DEFAULT;
   localparam int TABLE_DEPTH    = mscf_pkg::MAX_CANDIDATES_DEFAULT;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int QUIET_AFTER    = 950;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   mscf_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   mscf_pkg::rsp_type               rsp_data;
   logic                            csr_write_enable;
   logic [mscf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mscf_pkg::CSR_DATA_W-1:0] csr_write_data;

   int          mismatch_count;
   int          outstanding;
   int          requests_sent = 0;
   int          stuck_cycles  = 0;
   bit          quiet         = 1'b1;
   logic [1:0]  mode_now      = mscf_pkg::UNIT_SIZE_MODE_RESET;
   logic [7:0]  memory_image [MEM_SPAN] = '{default: 8'h00};
   int unsigned pass_addrs [$];

   memory_search_candidate_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   candidate_filter_checker filter_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic issue(input logic [1:0] kind, input int unsigned addr, input logic [7:0] data,
                        input logic [2:0] rel, input logic [31:0] test, input int unsigned idx);
      mscf_pkg::req_type r;
      r.kind        = kind;
      r.byte_addr   = addr[mscf_pkg::ADDR_W-1:0];
      r.mem_byte    = data;
      r.relation    = rel;
      r.test_value  = test;
      r.entry_index = idx[mscf_pkg::INDEX_W-1:0];
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // idle the request side, collect every pending result, let the last byte settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic prev);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= mscf_pkg::CSR_UNIT_SIZE_MODE;
      csr_write_data   <= mode;
      @(posedge clock);
      csr_index        <= mscf_pkg::CSR_USE_PREVIOUS_VALUE;
      csr_write_data   <= {1'b0, prev};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_now = mode;
   endtask

   task automatic finish_compare();
      issue(mscf_pkg::KIND_FINISH, $urandom_range(0, MEM_SPAN - 1), 8'($urandom), 3'($urandom),
            $urandom, $urandom);
   endtask

   task automatic read_entries(input int count, input int span);
      repeat (count)
         issue(mscf_pkg::KIND_READ, $urandom_range(0, MEM_SPAN - 1), 8'($urandom),
               3'($urandom), $urandom,
               ($urandom_range(0, 5) == 0) ? $urandom_range(0, TABLE_DEPTH - 1)
                                           : $urandom_range(0, span));
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // pass always opens at address 0; the rest is contiguous, usually from address 1
   task automatic build_pass(input int n);
      int unsigned base;
      case ($urandom_range(0, 5))
         0: base = $urandom_range(1, MEM_SPAN - n);
         1: base = MEM_SPAN - n + 1;
         default: base = 1;
      endcase
      pass_addrs.delete();
      pass_addrs = {pass_addrs, 0};
      for (int i = 0; i < n - 1; i++)
         pass_addrs = {pass_addrs, base + i};
   endtask

   task automatic mutate_memory();
      foreach (pass_addrs[i]) begin
         case ($urandom_range(0, 7))
            0: memory_image[pass_addrs[i]] = memory_image[pass_addrs[i]] + 8'd1;
            1: memory_image[pass_addrs[i]] = memory_image[pass_addrs[i]] - 8'd1;
            2: memory_image[pass_addrs[i]] = random_byte();
            default: ;
         endcase
      end
   endtask

   function automatic logic [31:0] pick_test();
      int unsigned a;
      a = pass_addrs[$urandom_range(0, pass_addrs.size() - 1)];
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         3: return $urandom_range(0, 15);
         default: begin
            case (mode_now)
               mscf_pkg::MODE_NIBBLE: return $urandom_range(0, 1) ? memory_image[a][7:4]
                                                                   : memory_image[a][3:0];
               mscf_pkg::MODE_BYTE:   return memory_image[a];
               mscf_pkg::MODE_HALF:   return {memory_image[a | 1], memory_image[a & ~32'd1]};
               default:               return {memory_image[a | 3], memory_image[a | 2],
                                              memory_image[a | 1], memory_image[a & ~32'd3]};
            endcase
         end
      endcase
   endfunction

   task automatic snapshot_pass(input bit skip_start);
      foreach (pass_addrs[i])
         if (!(skip_start && i == 0))
            issue(mscf_pkg::KIND_SNAPSHOT, pass_addrs[i], memory_image[pass_addrs[i]],
                  3'($urandom), $urandom, $urandom);
   endtask

   task automatic compare_pass(input logic [2:0] rel, input logic [31:0] test,
                               input int drop_rate, input bit skip_start);
      foreach (pass_addrs[i]) begin
         if (skip_start && i == 0)
            continue;
         if (drop_rate != 0 && $urandom_range(1, drop_rate) == 1)
            continue;
         issue(mscf_pkg::KIND_COMPARE, pass_addrs[i], memory_image[pass_addrs[i]], rel, test,
               $urandom);
      end
   endtask

   task automatic search_round();
      int         n;
      logic [2:0] rel;
      if ($urandom_range(0, 2) == 0)
         set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      n = $urandom_range(2, 24);
      build_pass(n);
      foreach (pass_addrs[i])
         memory_image[pass_addrs[i]] = random_byte();
      snapshot_pass($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 7) == 0) begin
         finish_compare();
         read_entries($urandom_range(0, 2), 2 * n + 4);
      end
      if ($urandom_range(0, 9) == 0)
         set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 4)) begin
         mutate_memory();
         rel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
         compare_pass(rel, pick_test(), ($urandom_range(0, 7) == 0) ? 5 : 0,
                      $urandom_range(0, 11) == 0);
         if ($urandom_range(0, 7) != 0) begin
            finish_compare();
            read_entries($urandom_range(0, 3), 2 * n + 4);
         end
      end
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3))
            issue(2'($urandom), $urandom_range(0, MEM_SPAN - 1), 8'($urandom), 3'($urandom),
                  $urandom, $urandom);
   endtask

   initial begin
      int start;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      quiet = 1'b0;

      // empty table straight after reset, finish with no pass
      issue(mscf_pkg::KIND_READ, 0, 8'h00, mscf_pkg::REL_EQ, 32'h0, TABLE_DEPTH - 1);
      issue(mscf_pkg::KIND_FINISH, MEM_SPAN - 1, 8'hFF, 3'd7, 32'hFFFF_FFFF, 0);

      set_config(mscf_pkg::MODE_NIBBLE, 1'b1);
      issue(mscf_pkg::KIND_SNAPSHOT, 0, 8'hF0, mscf_pkg::REL_EQ, 32'h0, 0);
      issue(mscf_pkg::KIND_SNAPSHOT, 1, 8'h0F, mscf_pkg::REL_EQ, 32'h0, 0);
      issue(mscf_pkg::KIND_COMPARE, 0, 8'hF1, mscf_pkg::REL_NE, 32'h0, 0);
      issue(mscf_pkg::KIND_COMPARE, 1, 8'h0F, mscf_pkg::REL_NE, 32'h0, 0);
      finish_compare();
      issue(mscf_pkg::KIND_READ, 0, 8'h00, mscf_pkg::REL_EQ, 32'h0, 0);
      issue(mscf_pkg::KIND_READ, 0, 8'h00, mscf_pkg::REL_EQ, 32'h0, 1);

      set_config(mscf_pkg::MODE_WORD, 1'b0);
      for (int a = 0; a < 4; a++)
         issue(mscf_pkg::KIND_SNAPSHOT, a, 8'hFF, mscf_pkg::REL_EQ, 32'h0, 0);
      for (int a = 0; a < 4; a++)
         issue(mscf_pkg::KIND_COMPARE, a, 8'hFF, mscf_pkg::REL_EQ, 32'hFFFF_FFFF, 0);
      finish_compare();
      // nothing below zero: table and count must survive
      for (int a = 0; a < 4; a++)
         issue(mscf_pkg::KIND_COMPARE, a, 8'h00, mscf_pkg::REL_LT, 32'h0, 0);
      finish_compare();
      issue(mscf_pkg::KIND_READ, 0, 8'h00, mscf_pkg::REL_EQ, 32'h0, 0);

      start = requests_sent;
      while (requests_sent - start < RANDOM_ITEMS) begin
         if (requests_sent - start >= QUIET_AFTER)
            quiet = 1'b1;
         else
            quiet = ($urandom_range(0, 4) == 0);
         search_round();
      end

      drain();
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> memory_search_candidate_filter.f
hdl/mscf_pkg.sv
hdl/mscf_ctrl.sv
hdl/mscf_datapath.sv
hdl/memory_search_candidate_filter.sv
tb/sv/candidate_filter_checker.sv
tb/sv/testbench.sv
